// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mie_pkg.sv =====
`timescale 1ns / 1ps
package mie_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned CntW  = $clog2(Width + 1);

  typedef logic [Width-1:0] word_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_MUL,
    ST_UPDATE,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic div_init;  // start a long division of dividend by divisor
    logic div_step;  // one restoring division bit
    logic mul_init;  // start quotient * cofactor mod m
    logic mul_step;  // one shift-and-add bit
    logic update;    // shift remainder sequence and cofactors
    logic finish;    // register the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic value_zero;
    logic rem_zero;
    logic div_last;
    logic mul_last;
  } status_t;

endpackage

// ===== src/mie_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mie_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mie_pkg::cmd_t    cmd_i,
  output mie_pkg::status_t status_o,
  input  logic [31:0]      value_i,
  input  logic [31:0]      modulus_i,
  output logic [31:0]      inverse_o,
  output logic             has_inverse_o
);

  localparam int unsigned W = mie_pkg::Width;
  localparam int unsigned C = mie_pkg::CntW;

  mie_pkg::word_t m_q, m_d;
  mie_pkg::word_t dvd_q, dvd_d, dvs_q, dvs_d;
  mie_pkg::word_t quo_q, quo_d, rem_q, rem_d;
  mie_pkg::word_t pco_q, pco_d, cco_q, cco_d;
  mie_pkg::word_t mx_q, mx_d, my_q, my_d, acc_q, acc_d;
  logic [C-1:0]   cnt_q, cnt_d;
  logic [31:0]    inv_q, inv_d;
  logic           flag_q, flag_d;

  logic [W:0]     trial;
  logic [W:0]     sub;
  logic [W:0]     acc_sum, x_dbl;
  mie_pkg::word_t acc_n, x_n, prev_red, next_co;

  // One restoring division bit: shift in the next dividend bit
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    sub   = trial - {1'b0, dvs_q};
  end

  // Modular add helpers for the shift-and-add multiplier
  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, mx_q};
    acc_n   = (acc_sum >= {1'b0, m_q}) ? W'(acc_sum - {1'b0, m_q}) : acc_sum[W-1:0];
    x_dbl   = {mx_q, 1'b0};
    x_n     = (x_dbl >= {1'b0, m_q}) ? W'(x_dbl - {1'b0, m_q}) : x_dbl[W-1:0];
    // prev cofactor is below 2m at worst, reduce once
    prev_red = (pco_q >= m_q) ? pco_q - m_q : pco_q;
    next_co  = (prev_red >= acc_q) ? prev_red - acc_q : m_q - (acc_q - prev_red);
  end

  // Advance the datapath registers
  always_comb begin
    m_d = m_q; dvd_d = dvd_q; dvs_d = dvs_q; quo_d = quo_q; rem_d = rem_q;
    pco_d = pco_q; cco_d = cco_q; mx_d = mx_q; my_d = my_q; acc_d = acc_q;
    cnt_d = cnt_q; inv_d = inv_q; flag_d = flag_q;
    if (cmd_i.load) begin
      m_d   = W'(modulus_i);
      dvd_d = W'(modulus_i);
      dvs_d = W'(value_i);
      pco_d = '0;
      cco_d = W'(1);
    end
    if (cmd_i.div_init) begin
      quo_d = dvd_q;
      rem_d = '0;
      cnt_d = C'(W);
    end
    if (cmd_i.div_step) begin
      if (!sub[W]) begin
        rem_d = sub[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - C'(1);
    end
    if (cmd_i.mul_init) begin
      // cofactor is already below m when m is above 1; quotient may not be
      mx_d  = cco_q;
      my_d  = quo_q;
      acc_d = '0;
      cnt_d = C'(W);
    end
    if (cmd_i.mul_step) begin
      if (my_q[0]) acc_d = acc_n;
      mx_d  = x_n;
      my_d  = my_q >> 1;
      cnt_d = cnt_q - C'(1);
    end
    if (cmd_i.update) begin
      pco_d = cco_q;
      cco_d = next_co;
      dvd_d = dvs_q;
      dvs_d = rem_q;
    end
    if (cmd_i.finish) begin
      flag_d = (dvs_q == W'(1));
      inv_d  = (dvs_q == W'(1)) ? 32'(cco_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; dvd_q <= dvd_d; dvs_q <= dvs_d; quo_q <= quo_d; rem_q <= rem_d;
    pco_q <= pco_d; cco_q <= cco_d; mx_q <= mx_d; my_q <= my_d; acc_q <= acc_d;
    inv_q <= inv_d; flag_q <= flag_d;
  end

  assign status_o.value_zero = (dvs_q == '0);
  assign status_o.rem_zero   = (rem_q == '0);
  assign status_o.div_last   = (cnt_q == C'(1));
  assign status_o.mul_last   = (cnt_q == C'(1));
  assign inverse_o     = inv_q;
  assign has_inverse_o = flag_q;

  `ASSERT_NEXT(a_flag_inv, cmd_i.finish && dvs_q != W'(1), !flag_q && inv_q == '0,
               "no inverse must report zero")
  `ASSERT_IMPL(a_rem_lt_div, cmd_i.update, rem_q < dvs_q, "remainder not below divisor")

endmodule

// ===== src/mie_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mie_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mie_pkg::cmd_t    cmd_o,
  input  mie_pkg::status_t status_i
);

  mie_pkg::state_e state_q, state_d;
  logic            ov_q, ov_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mie_pkg::ST_IDLE:     if (in_valid_i && !in_stall_o) state_d = mie_pkg::ST_DIV_INIT;
      mie_pkg::ST_DIV_INIT: state_d = status_i.value_zero ? mie_pkg::ST_DONE
                                                          : mie_pkg::ST_DIV;
      mie_pkg::ST_DIV:      if (status_i.div_last) state_d = mie_pkg::ST_MUL;
      mie_pkg::ST_MUL: begin
        // remainder known here; stop once it is zero
        if (status_i.rem_zero) state_d = mie_pkg::ST_DONE;
        else state_d = mie_pkg::ST_UPDATE;
      end
      mie_pkg::ST_UPDATE:   if (status_i.mul_last) state_d = mie_pkg::ST_DIV_INIT;
      // wait until the output register is free
      mie_pkg::ST_DONE:     if (!ov_q || !out_stall_i) state_d = mie_pkg::ST_IDLE;
      default:              state_d = mie_pkg::ST_IDLE;
    endcase
  end

  // Outputs per state
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      mie_pkg::ST_IDLE:     cmd_o.load = in_valid_i && !in_stall_o;
      mie_pkg::ST_DIV_INIT: cmd_o.div_init = 1'b1;
      mie_pkg::ST_DIV:      cmd_o.div_step = 1'b1;
      mie_pkg::ST_MUL:      cmd_o.mul_init = !status_i.rem_zero;
      mie_pkg::ST_UPDATE: begin
        cmd_o.mul_step = !status_i.mul_last;
        cmd_o.update   = status_i.mul_last;
      end
      mie_pkg::ST_DONE:     cmd_o.finish = !ov_q || !out_stall_i;
      default:              cmd_o = '0;
    endcase
  end

  // Hold the result until the consumer takes the transfer
  always_comb begin
    ov_d = ov_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (cmd_o.finish) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mie_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // Take a new item whenever idle; a waiting result sits in its own register
  assign in_stall_o  = (state_q != mie_pkg::ST_IDLE);
  assign out_valid_o = ov_q;

  `ASSERT_IMPL(a_no_overrun, cmd_o.finish, !ov_q || !out_stall_i, "result overwritten")
  `ASSERT_NEXT(a_load_busy, cmd_o.load, state_q == mie_pkg::ST_DIV_INIT, "load not started")

endmodule

// ===== src/modular_inverse_ext_euclid_unit.sv =====
`timescale 1ns / 1ps
// Modular inverse by the extended Euclidean algorithm, one item at a time. Each
// Euclid iteration runs a restoring division and a shift-and-add modular
// multiply on one shared datapath; the number k of iterations that leave a
// nonzero remainder stays below about 1.5*WIDTH. A zero value reports no
// inverse. The next item may be taken while a result waits in the output
// register; finishing waits until that register is free.
module modular_inverse_ext_euclid_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_i,
  input  logic [31:0] modulus_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] inverse_o,
  output logic        has_inverse_o
);

  mie_pkg::cmd_t    cmd;
  mie_pkg::status_t status;

  mie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  mie_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .value_i       (value_i),
    .modulus_i     (modulus_i),
    .inverse_o     (inverse_o),
    .has_inverse_o (has_inverse_o)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned ItemCount = 1300;
  localparam longint unsigned CycleLimit = 64'd12_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] value_i = '0;
  logic [31:0] modulus_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] inverse_o;
  logic        has_inverse_o;

  typedef struct {
    logic [31:0] inverse;
    logic        has_inverse;
  } inv_result_t;

  // One directed row: operands plus an optional typed-in answer
  typedef struct {
    logic [31:0] value;
    logic [31:0] modulus;
    bit          known;
    logic [31:0] inverse;
    logic        has_inverse;
  } inv_row_t;

  inv_result_t  pending_results[$];
  int unsigned  mismatch_count = 0;
  longint unsigned cycle_count = 0;
  bit           stim_done = 1'b0;

  modular_inverse_ext_euclid_unit i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Compute the inverse by extended Euclid, cofactor kept reduced mod m
  function automatic inv_result_t calc_inverse(logic [31:0] a, logic [31:0] m);
    inv_result_t r;
    logic [63:0] dvd, dvs, q, rm, prev_co, cur_co, nxt, prod;
    r.inverse = '0;
    r.has_inverse = 1'b0;
    if (a == 0) return r;
    dvd = m;
    dvs = a;
    prev_co = 0;
    cur_co = 1;
    q = dvd / dvs;
    rm = dvd % dvs;
    while (rm != 0) begin
      prod = ((q % m) * (cur_co % m)) % m;
      nxt = prev_co % m;
      nxt = (nxt >= prod) ? nxt - prod : m - (prod - nxt);
      prev_co = cur_co;
      cur_co = nxt;
      dvd = dvs;
      dvs = rm;
      q = dvd / dvs;
      rm = dvd % dvs;
    end
    if (dvs == 1) begin
      r.inverse = cur_co[31:0];
      r.has_inverse = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: stall on a pattern that changes mode now and then
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    inv_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", inverse_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (inverse_o !== want.inverse)
          report_mismatch("inverse", inverse_o, want.inverse);
        if (has_inverse_o !== want.has_inverse)
          report_mismatch("has_inverse", {31'b0, has_inverse_o}, {31'b0, want.has_inverse});
      end
    end
  end

  // Hold one item until it is transferred
  task automatic send_item(logic [31:0] a, logic [31:0] m, inv_result_t want);
    value_i <= a;
    modulus_i <= m;
    in_valid_i <= 1'b1;
    pending_results.push_back(want);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  inv_row_t directed_rows[$];

  initial begin
    inv_result_t want;
    int unsigned burst;
    logic [31:0] a, m;
    directed_rows = '{
      '{32'd0, 32'd7, 1, 32'd0, 1'b0},
      '{32'd0, 32'd0, 1, 32'd0, 1'b0},
      '{32'd1, 32'd0, 1, 32'd1, 1'b1},
      '{32'd1, 32'd1, 1, 32'd1, 1'b1},
      '{32'd1, 32'hFFFF_FFFF, 1, 32'd1, 1'b1},
      '{32'd5, 32'd0, 1, 32'd0, 1'b0},
      '{32'hFFFF_FFFF, 32'd0, 1, 32'd0, 1'b0},
      '{32'd4, 32'd8, 1, 32'd0, 1'b0},
      '{32'd3, 32'd7, 1, 32'd5, 1'b1},
      '{32'd10, 32'd7, 0, '0, 1'b0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 0, '0, 1'b0},
      '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 0, '0, 1'b0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0, 1'b0},
      '{32'h8000_0001, 32'h7FFF_FFFF, 0, '0, 1'b0},
      '{32'hB504_F333, 32'hFFFF_FFFB, 0, '0, 1'b0},
      '{32'h5555_5555, 32'hAAAA_AAAB, 0, '0, 1'b0},
      '{32'd2, 32'd1, 0, '0, 1'b0},
      '{32'd17, 32'd3, 0, '0, 1'b0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].known) begin
        want.inverse = directed_rows[i].inverse;
        want.has_inverse = directed_rows[i].has_inverse;
      end else begin
        want = calc_inverse(directed_rows[i].value, directed_rows[i].modulus);
      end
      send_item(directed_rows[i].value, directed_rows[i].modulus, want);
    end
    in_valid_i <= 1'b0;

    // Random bursts, most of them followed by a gap
    for (int unsigned n = 0; n < ItemCount; ) begin
      burst = $urandom_range(1, 12);
      for (int unsigned k = 0; k < burst && n < ItemCount; k++, n++) begin
        a = rand_word();
        m = rand_word();
        if ($urandom_range(0, 3) == 0) m |= 32'd1;
        send_item(a, m, calc_inverse(a, m));
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 120)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // Drain and let any trailing activity show
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== modular_inverse_ext_euclid_unit.f =====
+incdir+src
src/mie_pkg.sv
src/mie_datapath.sv
src/mie_ctrl.sv
src/modular_inverse_ext_euclid_unit.sv
verif/tb_top.sv
